>>> design/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// Depends on nothing; imported by sha1md_sched and sha1_message_digest.
package sha1md_pkg;

    localparam int ROUNDS = 80;
    localparam int ROUND_W = 7;
    localparam int DIGEST_WORDS = 5;

    localparam logic [31:0] HASH_INIT [0:DIGEST_WORDS-1] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [31:0] K_ROUND0 = 32'h5a82_7999;
    localparam logic [31:0] K_ROUND1 = 32'h6ed9_eba1;
    localparam logic [31:0] K_ROUND2 = 32'h8f1b_bcdc;
    localparam logic [31:0] K_ROUND3 = 32'hca62_c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PADB,
        S_FILL,
        S_PRE,
        S_ROUND,
        S_ADD,
        S_DONE
    } state_t;

    // Control from the sequencer to the message schedule memories.
    typedef struct packed {
        logic       ld_we;
        logic [3:0] ld_addr;
        logic [3:0] rd_idx;
        logic       rnd_en;
        logic       expand;
        logic [3:0] cur_idx;
    } sched_ctl_t;

endpackage

>>> design/sha1md_sched.sv
// Message schedule: the 16-word block held in two mirrored synchronous memories.
// Depends on sha1md_pkg for the control struct.
module sha1md_sched (
    input  logic                   aclk,
    input  sha1md_pkg::sched_ctl_t ctl,
    input  logic [31:0]            ld_data,
    output logic [31:0]            wt
);
    import sha1md_pkg::*;

    // Both memories get every write; each serves two read addresses.
    logic [31:0] mem_a [0:15];
    logic [31:0] mem_b [0:15];

    logic [31:0] rd_m3_reg;
    logic [31:0] rd_m8_reg;
    logic [31:0] rd_m14_reg;
    logic [31:0] rd_cur_reg;

    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [31:0] mix;
    logic [31:0] w_exp;

    assign mix   = rd_m3_reg ^ rd_m8_reg ^ rd_m14_reg ^ rd_cur_reg;
    assign w_exp = {mix[30:0], mix[31]};
    assign wt    = ctl.expand ? w_exp : rd_cur_reg;

    assign wr_en   = ctl.ld_we | (ctl.rnd_en & ctl.expand);
    assign wr_addr = ctl.rnd_en ? ctl.cur_idx : ctl.ld_addr;
    assign wr_data = ctl.rnd_en ? w_exp : ld_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
    end

    // Registered reads for the next round.
    always_ff @(posedge aclk) begin
        rd_m3_reg  <= mem_a[ctl.rd_idx - 4'd3];
        rd_m8_reg  <= mem_a[ctl.rd_idx - 4'd8];
        rd_m14_reg <= mem_b[ctl.rd_idx - 4'd14];
        rd_cur_reg <= mem_b[ctl.rd_idx];
    end

endmodule

>>> design/sha1_message_digest.sv
// SHA-1 message digest top level: byte loader, padding sequencer, round datapath
// and digest output register. Depends on sha1md_pkg and sha1md_sched.
//
// Usage: message bytes arrive one per request on the s_ channel. A request with
// s_byte_valid high carries a byte; a request with s_end_of_message high closes the
// message (after its byte, if it carries one). A closing request may carry no byte,
// so an empty message can be hashed. For each closed message the m_ channel
// delivers five requests, digest word 0 first, with m_word_index 0 to 4 and
// m_last_word high on the fifth.
// Bytes are taken only while the block is idle (s_ready high). Every 64th byte starts
// a compression (a load state, the 80 rounds and an add state), run by the single
// round unit reading the schedule memories once per round.
// After a closing request (and the compression of a block it fills), padding writes
// one word per cycle up to the end of the block, then one or two compressions follow
// before the digest is loaded into the output register.
// The digest is held in its own output register, so bytes of the next message are
// accepted while the receiver stalls; only a second closing request waits for the
// previous digest to drain.
// Reset (aresetn low, synchronous) restores the initial hash, clears the bit and
// byte counts and drops m_valid. The block words need no clearing.
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_message_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1md_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg [0:DIGEST_WORDS-1];
    logic [31:0] hash_next [0:DIGEST_WORDS-1];
    logic [31:0] vars_reg [0:DIGEST_WORDS-1];
    logic [31:0] vars_next [0:DIGEST_WORDS-1];
    logic [31:0] dig_reg [0:DIGEST_WORDS-1];
    logic [31:0] dig_next [0:DIGEST_WORDS-1];
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] pack_reg, pack_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [3:0]  widx_reg, widx_next;
    logic        end_pend_reg, end_pend_next;
    logic        more_reg, more_next;
    logic        final_reg, final_next;
    logic        busy_reg, busy_next;
    logic [2:0]  oidx_reg, oidx_next;

    sched_ctl_t  ctl;
    logic [31:0] ld_data;
    logic [31:0] wt;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] pad_word;

    sha1md_sched u_sched (
        .aclk    (aclk),
        .ctl     (ctl),
        .ld_data (ld_data),
        .wt      (wt)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = busy_reg;
    assign m_digest_word = dig_reg[0];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 3'(DIGEST_WORDS - 1));

    // Round function and constant by round group.
    always_comb begin
        if (rnd_reg < ROUND_W'(20)) begin
            f_val = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            k_val = K_ROUND0;
        end else if (rnd_reg < ROUND_W'(40)) begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_ROUND1;
        end else if (rnd_reg < ROUND_W'(60)) begin
            f_val = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
                  | (vars_reg[2] & vars_reg[3]);
            k_val = K_ROUND2;
        end else begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_ROUND3;
        end
    end

    // The padding byte lands after the bytes already packed; lower lanes are zero.
    always_comb begin
        case (pos_reg[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'd0};
            2'd1: pad_word = {pack_reg[31:24], PAD_BYTE, 16'd0};
            2'd2: pad_word = {pack_reg[31:16], PAD_BYTE, 8'd0};
            2'd3: pad_word = {pack_reg[31:8], PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'd0};
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        vars_next     = vars_reg;
        dig_next      = dig_reg;
        bitcnt_next   = bitcnt_reg;
        pos_next      = pos_reg;
        pack_next     = pack_reg;
        rnd_next      = rnd_reg;
        widx_next     = widx_reg;
        end_pend_next = end_pend_reg;
        more_next     = more_reg;
        final_next    = final_reg;
        busy_next     = busy_reg;
        oidx_next     = oidx_reg;

        ctl.ld_we   = 1'b0;
        ctl.ld_addr = pos_reg[5:2];
        ctl.rd_idx  = rnd_reg[3:0] + 4'd1;
        ctl.rnd_en  = 1'b0;
        ctl.expand  = (rnd_reg >= ROUND_W'(16));
        ctl.cur_idx = rnd_reg[3:0];
        ld_data     = {pack_reg[31:8], s_message_byte};

        // Digest words drain independently of the rest of the block.
        if (busy_reg && m_ready) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                dig_next[i] = dig_reg[i+1];
            end
            oidx_next = oidx_reg + 3'd1;
            if (oidx_reg == 3'(DIGEST_WORDS - 1)) begin
                busy_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_byte_valid) begin
                        case (pos_reg[1:0])
                            2'd0: pack_next[31:24] = s_message_byte;
                            2'd1: pack_next[23:16] = s_message_byte;
                            2'd2: pack_next[15:8]  = s_message_byte;
                            2'd3: pack_next[7:0]   = s_message_byte;
                            default: pack_next = pack_reg;
                        endcase
                        ctl.ld_we   = (pos_reg[1:0] == 2'd3);
                        bitcnt_next = bitcnt_reg + 64'd8;
                        pos_next    = pos_reg + 6'd1;
                        if (pos_reg == 6'd63) begin
                            end_pend_next = s_end_of_message;
                            state_next    = S_PRE;
                        end else if (s_end_of_message) begin
                            state_next = S_PADB;
                        end
                    end else if (s_end_of_message) begin
                        state_next = S_PADB;
                    end
                end
            end
            S_PADB: begin
                ctl.ld_we = 1'b1;
                ld_data   = pad_word;
                if (pos_reg[5:2] == LEN_LO_IDX) begin
                    // No room for the length: this block is compressed as it is.
                    more_next  = 1'b1;
                    state_next = S_PRE;
                end else if (pos_reg[5:2] == LEN_HI_IDX) begin
                    more_next  = 1'b1;
                    widx_next  = LEN_LO_IDX;
                    state_next = S_FILL;
                end else begin
                    more_next  = 1'b0;
                    widx_next  = pos_reg[5:2] + 4'd1;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                ctl.ld_we   = 1'b1;
                ctl.ld_addr = widx_reg;
                if (!more_reg && widx_reg == LEN_HI_IDX) begin
                    ld_data = bitcnt_reg[63:32];
                end else if (!more_reg && widx_reg == LEN_LO_IDX) begin
                    ld_data = bitcnt_reg[31:0];
                end else begin
                    ld_data = 32'd0;
                end
                widx_next = widx_reg + 4'd1;
                if (widx_reg == LEN_LO_IDX) begin
                    final_next = !more_reg;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                ctl.rd_idx = 4'd0;
                vars_next  = hash_reg;
                rnd_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                ctl.rnd_en   = 1'b1;
                vars_next[0] = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val
                             + vars_reg[4] + wt + k_val;
                vars_next[1] = vars_reg[0];
                vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
                vars_next[3] = vars_reg[2];
                vars_next[4] = vars_reg[3];
                rnd_next     = rnd_reg + ROUND_W'(1);
                if (rnd_reg == ROUND_W'(ROUNDS - 1)) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                if (end_pend_reg) begin
                    end_pend_next = 1'b0;
                    state_next    = S_PADB;
                end else if (more_reg) begin
                    more_next  = 1'b0;
                    widx_next  = 4'd0;
                    state_next = S_FILL;
                end else if (final_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DONE: begin
                // Wait until the previous digest has been fully taken.
                if (!busy_reg) begin
                    dig_next    = hash_reg;
                    busy_next   = 1'b1;
                    oidx_next   = 3'd0;
                    hash_next   = HASH_INIT;
                    bitcnt_next = 64'd0;
                    pos_next    = 6'd0;
                    final_next  = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hash_reg     <= HASH_INIT;
            bitcnt_reg   <= 64'd0;
            pos_reg      <= 6'd0;
            rnd_reg      <= '0;
            widx_reg     <= 4'd0;
            end_pend_reg <= 1'b0;
            more_reg     <= 1'b0;
            final_reg    <= 1'b0;
            busy_reg     <= 1'b0;
            oidx_reg     <= 3'd0;
        end else begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            bitcnt_reg   <= bitcnt_next;
            pos_reg      <= pos_next;
            rnd_reg      <= rnd_next;
            widx_reg     <= widx_next;
            end_pend_reg <= end_pend_next;
            more_reg     <= more_next;
            final_reg    <= final_next;
            busy_reg     <= busy_next;
            oidx_reg     <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pack_reg <= pack_next;
        vars_reg <= vars_next;
        dig_reg  <= dig_next;
    end

`ifndef SYNTHESIS
    // A new digest always starts with word 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_word_index == 3'd0))
        else $error("digest did not start at word 0");

    // After the last word is taken, no further word follows in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> !m_valid)
        else $error("digest word after the last one");

    // The 64th byte of a block starts a compression at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_byte_valid && pos_reg == 6'd63) |=> (state_reg == S_PRE))
        else $error("full block did not start compression");

    // The round counter stays within the 80 rounds while rounds run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (rnd_reg < ROUND_W'(ROUNDS)))
        else $error("round counter out of range");
`endif

endmodule
